@@ rtl/two_sensor_passage_counter_top_assert.svh @@
// Assertion macros for the passage counter. In simulation they expand to
// concurrent assertions on the rising edge of aclk; in synthesis they vanish.
`ifndef TWO_SENSOR_PASSAGE_COUNTER_TOP_ASSERT_SVH
`define TWO_SENSOR_PASSAGE_COUNTER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Checked outside of reset only.
`define TSPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define TSPC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define TSPC_ASSERT(lbl, prop, msg)
`define TSPC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/tspc_pkg.sv @@
package tspc_pkg;

    // Event codes reported with each result.
    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_ENTER   = 3'd1;
    localparam logic [2:0] EV_LEAVE   = 3'd2;
    localparam logic [2:0] EV_TIMEOUT = 3'd3;
    localparam logic [2:0] EV_INVALID = 3'd4;

    // Capacity status codes.
    localparam logic [1:0] CAP_UNDER = 2'd0;
    localparam logic [1:0] CAP_AT    = 2'd1;
    localparam logic [1:0] CAP_OVER  = 2'd2;

    // Side codes for the passage tracking.
    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_A    = 2'd1;
    localparam logic [1:0] SIDE_B    = 2'd2;

    // Input function codes.
    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_NEAR_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_CAPACITY_LIMIT = 2'd1;
    localparam logic [1:0] CFG_TIMEOUT_TICKS  = 2'd2;
    localparam logic [1:0] CFG_HOLDOFF_TICKS  = 2'd3;

    localparam int CFG_DATA_W = 24;

    // Configuration reset values.
    localparam logic [15:0] NEAR_THRESHOLD_RST = 16'd1000;
    localparam logic [14:0] CAPACITY_LIMIT_RST = 15'd10;
    localparam logic [23:0] TIMEOUT_TICKS_RST  = 24'd2500;
    localparam logic [23:0] HOLDOFF_TICKS_RST  = 24'd3000;

    typedef struct packed {
        logic        func;
        logic [15:0] dist_side_a;
        logic [15:0] dist_side_b;
    } tspc_in_t;

    typedef struct packed {
        logic [2:0]         event_code;
        logic signed [15:0] occupancy;
        logic [1:0]         capacity_status;
        logic               passage_busy;
    } tspc_out_t;

endpackage

@@ rtl/two_sensor_passage_counter_top.sv @@
// Two-sensor passage counter.
// The input channel (s_valid, s_ready, s_data) carries one transaction per
// sensor sample pair (func = 0) or per timer tick (func = 1). Every input
// transaction produces exactly one result transaction on the output channel
// (m_valid, m_ready, m_data) with the event code, the occupancy count, the
// capacity status and the passage busy flag after that input.
// An accepted transaction lands in the input register, is evaluated against
// the tracking state and is written to the output register. One transaction
// is taken per cycle while the receiver does not stall; the tracking state
// is updated as each result is written to the output register.
// When the receiver stalls, the result waits in the output register while
// one more transaction may sit in the input register; s_ready drops only
// when both are full and m_ready is low.
// Configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata, by the user only while the block is idle (not enforced).
// Reset (aresetn low, synchronous) empties both registers, clears the
// tracking, timers and count, and restores the default configuration.
module two_sensor_passage_counter_top
    import tspc_pkg::*;
#(
    parameter int COUNT_WIDTH = 16,
    parameter int TIMER_WIDTH = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  tspc_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tspc_out_t             m_data,
    input  logic                  cfg_wr_en,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "two_sensor_passage_counter_top_assert.svh"

    localparam int CMP_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
    localparam logic signed [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);
    localparam logic [TIMER_WIDTH-1:0]        TMR_ONE = TIMER_WIDTH'(1);

    // Configuration registers.
    logic [15:0] near_threshold_reg;
    logic [14:0] capacity_limit_reg;
    logic [23:0] timeout_ticks_reg;
    logic [23:0] holdoff_ticks_reg;

    // Pipeline registers.
    logic      in_valid_reg;
    tspc_in_t  in_data_reg;
    logic      m_valid_reg;
    tspc_out_t m_data_reg;

    // Tracking state.
    logic [1:0]                    first_side_reg, first_side_next;
    logic [1:0]                    second_side_reg, second_side_next;
    logic                          passage_done_reg, passage_done_next;
    logic                          timeout_armable_reg, timeout_armable_next;
    logic [TIMER_WIDTH-1:0]        timeout_remaining_reg, timeout_remaining_next;
    logic [TIMER_WIDTH-1:0]        holdoff_remaining_reg, holdoff_remaining_next;
    logic signed [COUNT_WIDTH-1:0] people_count_reg, people_count_next;

    logic      advance;
    logic      near_a;
    logic      near_b;
    logic [2:0] event_next;
    tspc_out_t m_data_next;
    logic [TIMER_WIDTH-1:0]  timeout_load;
    logic [TIMER_WIDTH-1:0]  tmr_dec;
    logic signed [CMP_W-1:0] count_ext;
    logic signed [CMP_W-1:0] cap_ext;

    // Handshake: the input register passes its transaction on whenever the output register can
    // take its result.
    assign advance = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_threshold_reg <= NEAR_THRESHOLD_RST;
            capacity_limit_reg <= CAPACITY_LIMIT_RST;
            timeout_ticks_reg  <= TIMEOUT_TICKS_RST;
            holdoff_ticks_reg  <= HOLDOFF_TICKS_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_NEAR_THRESHOLD: near_threshold_reg <= cfg_wdata[15:0];
                CFG_CAPACITY_LIMIT: capacity_limit_reg <= cfg_wdata[14:0];
                CFG_TIMEOUT_TICKS:  timeout_ticks_reg  <= cfg_wdata;
                CFG_HOLDOFF_TICKS:  holdoff_ticks_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    assign near_a       = in_data_reg.dist_side_a <= near_threshold_reg;
    assign near_b       = in_data_reg.dist_side_b <= near_threshold_reg;
    assign timeout_load = (TIMER_WIDTH'(timeout_ticks_reg) == '0) ? TMR_ONE
                                                                 : TIMER_WIDTH'(timeout_ticks_reg);
    assign tmr_dec      = timeout_remaining_reg - TMR_ONE;

    // Evaluate one transaction against the tracking state.
    always_comb begin
        first_side_next        = first_side_reg;
        second_side_next       = second_side_reg;
        passage_done_next      = passage_done_reg;
        timeout_armable_next   = timeout_armable_reg;
        timeout_remaining_next = timeout_remaining_reg;
        holdoff_remaining_next = holdoff_remaining_reg;
        people_count_next      = people_count_reg;
        event_next             = EV_NONE;

        if (in_data_reg.func == FUNC_TICK) begin
            // Tick: count down hold-off and timeout; expiry clears tracking, loads hold-off.
            if (holdoff_remaining_reg != '0) begin
                holdoff_remaining_next = holdoff_remaining_reg - TMR_ONE;
            end
            if (timeout_remaining_reg != '0) begin
                timeout_remaining_next = tmr_dec;
                if (tmr_dec == '0) begin
                    timeout_armable_next   = 1'b1;
                    first_side_next        = SIDE_NONE;
                    second_side_next       = SIDE_NONE;
                    passage_done_next      = 1'b0;
                    holdoff_remaining_next = TIMER_WIDTH'(holdoff_ticks_reg);
                    event_next             = EV_TIMEOUT;
                end
            end
        end else if (holdoff_remaining_reg == '0) begin
            // Sample pair outside hold-off: update which side went near first and second.
            if (near_a && !near_b) begin
                if (first_side_reg == SIDE_NONE) begin
                    first_side_next = SIDE_A;
                end
                second_side_next = (first_side_next == SIDE_B) ? SIDE_A : SIDE_NONE;
            end else if (!near_a && near_b) begin
                if (first_side_reg == SIDE_NONE) begin
                    first_side_next = SIDE_B;
                end
                second_side_next = (first_side_next == SIDE_A) ? SIDE_B : SIDE_NONE;
            end else if (!near_a && !near_b) begin
                passage_done_next = (second_side_reg != SIDE_NONE);
            end

            if (passage_done_next) begin
                // Both sides clear after a second side: the passage is complete.
                timeout_armable_next   = 1'b1;
                timeout_remaining_next = '0;
                if (first_side_next == SIDE_A) begin
                    if (people_count_reg != CNT_MAX) begin
                        people_count_next = people_count_reg + CNT_ONE;
                    end
                    event_next = EV_ENTER;
                end else if (first_side_next == SIDE_B) begin
                    if (people_count_reg != CNT_MIN) begin
                        people_count_next = people_count_reg - CNT_ONE;
                    end
                    event_next = EV_LEAVE;
                end else begin
                    event_next = EV_INVALID;
                end
                first_side_next   = SIDE_NONE;
                second_side_next  = SIDE_NONE;
                passage_done_next = 1'b0;
            end else if (first_side_next != SIDE_NONE && timeout_armable_reg) begin
                // A passage has started: arm the timeout once.
                timeout_armable_next   = 1'b0;
                timeout_remaining_next = timeout_load;
            end
        end
    end

    // Capacity comparison on the updated count.
    assign count_ext = CMP_W'(people_count_next);
    assign cap_ext   = CMP_W'(capacity_limit_reg);

    always_comb begin
        m_data_next.event_code   = event_next;
        m_data_next.occupancy    = count_ext[15:0];
        m_data_next.passage_busy = (first_side_next != SIDE_NONE);
        if (count_ext == cap_ext) begin
            m_data_next.capacity_status = CAP_AT;
        end else if (count_ext > cap_ext) begin
            m_data_next.capacity_status = CAP_OVER;
        end else begin
            m_data_next.capacity_status = CAP_UNDER;
        end
    end

    // State update, one transaction per cycle while the output register can take a result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_side_reg        <= SIDE_NONE;
            second_side_reg       <= SIDE_NONE;
            passage_done_reg      <= 1'b0;
            timeout_armable_reg   <= 1'b1;
            timeout_remaining_reg <= '0;
            holdoff_remaining_reg <= '0;
            people_count_reg      <= '0;
        end else if (advance) begin
            first_side_reg        <= first_side_next;
            second_side_reg       <= second_side_next;
            passage_done_reg      <= passage_done_next;
            timeout_armable_reg   <= timeout_armable_next;
            timeout_remaining_reg <= timeout_remaining_next;
            holdoff_remaining_reg <= holdoff_remaining_next;
            people_count_reg      <= people_count_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= m_data_next;
        end
    end

    // A hold-off only follows an expired timeout, so the timer is idle then.
    `TSPC_ASSERT_ALWAYS(a_holdoff_timer_idle, (holdoff_remaining_reg != '0) |-> (timeout_remaining_reg == '0), "Timeout running during hold-off.")
    // A running timeout belongs to a started passage and is not re-armable.
    `TSPC_ASSERT_ALWAYS(a_timer_has_passage, (timeout_remaining_reg != '0) |-> (first_side_reg != SIDE_NONE && !timeout_armable_reg), "Timeout running without a passage.")
    // A second side is only recorded after a first side.
    `TSPC_ASSERT_ALWAYS(a_second_needs_first, (first_side_reg == SIDE_NONE) |-> (second_side_reg == SIDE_NONE), "Second side without first side.")
    // A completed passage is consumed in the same transaction.
    `TSPC_ASSERT(a_done_consumed, !passage_done_reg, "Completed passage left pending.")
    // The input register holds a transaction that cannot move on.
    `TSPC_ASSERT(a_stall_holds_input, (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_data_reg)), "Pending transaction lost.")

endmodule
